/* design/spatial_bin_counting_sort_unit_defines.svh */
// Assertion macros shared by the spatial binning sort design.
// The macros assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef SPATIAL_BIN_COUNTING_SORT_UNIT_DEFINES_SVH
`define SPATIAL_BIN_COUNTING_SORT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBCS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/sbcs_pkg.sv */
// Package for the spatial binning counting sort: sizes, codes, payload types.
// No dependencies; the top level and the divider import it.
package sbcs_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int MAX_BINS  = 1024;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int BIN_AW    = $clog2(MAX_BINS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);

  // Fixed field widths.
  localparam int REG_W  = 23;
  localparam int POS_W  = 24;
  localparam int SIDE_W = 24;
  localparam int DIM_W  = 24;
  localparam int OUT_W  = 11;
  localparam int IDX_W  = 10;

  // Width of the divider's step counter.
  localparam int DIV_CW = $clog2(REG_W + 1);

  localparam logic [SIDE_W-1:0] UNIT_SIDE = 24'd256;
  localparam logic [OUT_W-1:0]  SAT_BINS  = 11'd1024;

  // Operation codes.
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_READ_BIN = 2'd1;
  localparam logic [1:0] OP_READ_SLT = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CELL_OVF  = 2'd1;
  localparam logic [1:0] ST_BIN_OVF   = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_PITCH  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    last;
    logic [IDX_W-1:0]        index;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] bin_base;
    logic [OUT_W-1:0] bin_size;
    logic [IDX_W-1:0] sorted_cell;
    logic [OUT_W-1:0] bins_across;
    logic [OUT_W-1:0] bins_down;
  } out_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [REG_W-1:0]  dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [REG_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WA, S_WW, S_HA, S_HW, S_CHECK, S_XA, S_XW, S_YA, S_YW,
    S_STORE, S_RDW, S_CLR, S_CNT_A, S_CNT_B, S_CNT_C, S_PFX_A, S_PFX_B,
    S_SC_A, S_SC_B, S_SC_C, S_DONE
  } state_t;

endpackage

/* design/spatial_bin_counting_sort_unit.sv */
// Top level of the spatial binning counting sort: sequencer, registers, memories.
// Depends on sbcs_pkg, sbcs_divider, sbcs_ram and the assertion macro header.
//
//   Channel  Ports                           Direction  Carries
//   in       in_valid, in_stall, in_data     input      op, position, last, index
//   out      out_valid, out_stall, out_data  output     status, read fields, grid size
//   cfg      cfg_we, cfg_index, cfg_wdata    input      register writes
//
// A division on the shared divider runs through start, the restoring steps and done. Every item
// runs two for the grid size, then a dispatch and a hand-over state. A read adds one RAM read,
// a load two more divisions and a store. A last load then builds: it clears every count,
// counts the cells, sums the counts into start offsets and scatters the cells, each phase
// bounded by one RAM port.
// Reset is synchronous; a valid result holds in the result register while out_stall is high.
`include "spatial_bin_counting_sort_unit_defines.svh"

module spatial_bin_counting_sort_unit
  import sbcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [REG_W-1:0] radius_r, pitch_r, width_r, height_r;

  state_t state_r, state_nxt;

  logic [1:0]        op_r, op_nxt;
  logic              last_r, last_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic [SIDE_W-1:0] side_r, side_nxt, side_c;
  logic [DIM_W-1:0]  across_r, across_nxt, down_r, down_nxt;
  logic [BIN_AW-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [CNT_W-1:0]  cells_r, cells_nxt, cells_eff;
  logic              built_r, built_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [BIN_AW-1:0] cb_r, cb_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  bstart_r, bstart_nxt, bcount_r, bcount_nxt;
  logic [IDX_W-1:0]  scell_r, scell_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic [SIDE_W-1:0] radius_x2;
  logic [DIM_W-1:0]  quo_ext;
  logic [2*OUT_W-1:0] grid_prod;
  logic              grid_ovf;
  logic [20:0]       bin_lin;
  logic [REG_W-1:0]  clamp_q;
  logic [BIN_AW-1:0] clamp_b;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // RAM port controls.
  logic              cb_we;
  logic [CELL_AW-1:0] cb_waddr, cb_raddr;
  logic [BIN_AW-1:0] cb_wdata, cb_rdata;
  logic              cn_we;
  logic [BIN_AW-1:0] cn_waddr, cn_raddr;
  logic [CNT_W-1:0]  cn_wdata, cn_rdata;
  logic              st_we;
  logic [BIN_AW-1:0] st_waddr, st_raddr;
  logic [CNT_W-1:0]  st_wdata, st_rdata;
  logic              cu_we;
  logic [BIN_AW-1:0] cu_waddr, cu_raddr;
  logic [CNT_W-1:0]  cu_wdata, cu_rdata;
  logic              so_we;
  logic [CELL_AW-1:0] so_waddr, so_raddr;
  logic [CELL_AW-1:0] so_wdata, so_rdata;

  sbcs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sbcs_ram #(.WIDTH(BIN_AW), .DEPTH(MAX_CELLS)) u_cell_bin (
    .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
    .raddr(cb_raddr), .rdata(cb_rdata)
  );

  sbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_counts (
    .clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
    .raddr(cn_raddr), .rdata(cn_rdata)
  );

  sbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_starts (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  sbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_cursors (
    .clk(clk), .we(cu_we), .waddr(cu_waddr), .wdata(cu_wdata),
    .raddr(cu_raddr), .rdata(cu_rdata)
  );

  sbcs_ram #(.WIDTH(CELL_AW), .DEPTH(MAX_CELLS)) u_sorted (
    .clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
    .raddr(so_raddr), .rdata(so_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= REG_W'(256);
      pitch_r  <= REG_W'(256);
      width_r  <= REG_W'(65536);
      height_r <= REG_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_PITCH:  pitch_r  <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    radius_r <= radius_r;
      endcase
    end
  end

  // Bin side: twice the radius, at least the pitch, one unit if zero.
  always_comb begin
    radius_x2 = {radius_r, 1'b0};
    side_c    = (radius_x2 < {1'b0, pitch_r}) ? {1'b0, pitch_r} : radius_x2;
    if (side_c == '0) begin
      side_c = UNIT_SIDE;
    end
  end

  assign quo_ext   = {1'b0, div_rsp.quotient} + DIM_W'(1);
  assign grid_prod = across_r[OUT_W-1:0] * down_r[OUT_W-1:0];
  assign grid_ovf  = (across_r > DIM_W'(MAX_BINS)) || (down_r > DIM_W'(MAX_BINS)) ||
                     (grid_prod > (2*OUT_W)'(MAX_BINS));
  assign bin_lin   = by_r * across_r[OUT_W-1:0] + 21'(bx_r);
  assign cells_eff = built_r ? '0 : cells_r;

  // Clamp a finished axis quotient into the grid along that axis.
  always_comb begin
    clamp_q = div_rsp.quotient;
    if (state_r == S_XW) begin
      clamp_b = ({1'b0, clamp_q} >= across_r) ? BIN_AW'(across_r - 1'b1)
                                              : BIN_AW'(clamp_q);
    end else begin
      clamp_b = ({1'b0, clamp_q} >= down_r) ? BIN_AW'(down_r - 1'b1)
                                            : BIN_AW'(clamp_q);
    end
  end

  // Sequencer: next state, datapath updates and memory controls.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    side_nxt      = side_r;
    across_nxt    = across_r;
    down_nxt      = down_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    cells_nxt     = cells_r;
    built_nxt     = built_r;
    ptr_nxt       = ptr_r;
    acc_nxt       = acc_r;
    cb_nxt        = cb_r;
    status_nxt    = status_r;
    bstart_nxt    = bstart_r;
    bcount_nxt    = bcount_r;
    scell_nxt     = scell_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    in_stall      = (state_r != S_IDLE);

    div_req.start    = 1'b0;
    div_req.dividend = width_r;
    div_req.divisor  = side_r;

    cb_we = 1'b0; cb_waddr = cells_r[CELL_AW-1:0]; cb_wdata = bin_lin[BIN_AW-1:0];
    cb_raddr = ptr_r[CELL_AW-1:0];
    cn_we = 1'b0; cn_waddr = ptr_r[BIN_AW-1:0]; cn_wdata = '0;
    cn_raddr = idx_r;
    st_we = 1'b0; st_waddr = ptr_r[BIN_AW-1:0]; st_wdata = acc_r;
    st_raddr = idx_r;
    cu_we = 1'b0; cu_waddr = ptr_r[BIN_AW-1:0]; cu_wdata = acc_r;
    cu_raddr = cb_rdata;
    so_we = 1'b0; so_waddr = cu_rdata[CELL_AW-1:0]; so_wdata = ptr_r[CELL_AW-1:0];
    so_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          last_nxt  = in_data.last;
          idx_nxt   = in_data.index;
          px_nxt    = in_data.pos_x;
          py_nxt    = in_data.pos_y;
          side_nxt  = side_c;
          state_nxt = S_WA;
        end
      end
      // Grid size along x and y.
      S_WA: begin
        div_req.start = 1'b1;
        state_nxt     = S_WW;
      end
      S_WW: begin
        if (div_rsp.done) begin
          across_nxt = quo_ext;
          state_nxt  = S_HA;
        end
      end
      S_HA: begin
        div_req.start    = 1'b1;
        div_req.dividend = height_r;
        state_nxt        = S_HW;
      end
      S_HW: begin
        if (div_rsp.done) begin
          down_nxt  = quo_ext;
          state_nxt = S_CHECK;
        end
      end
      // Dispatch on the operation.
      S_CHECK: begin
        status_nxt = ST_OK;
        bstart_nxt = '0;
        bcount_nxt = '0;
        scell_nxt  = '0;
        state_nxt  = S_DONE;
        case (op_r)
          OP_LOAD: begin
            cells_nxt = cells_eff;
            built_nxt = 1'b0;
            if (cells_eff >= CNT_W'(MAX_CELLS)) begin
              status_nxt = ST_CELL_OVF;
              state_nxt  = last_r ? S_CLR : S_DONE;
            end else if (grid_ovf) begin
              status_nxt = ST_BIN_OVF;
              state_nxt  = last_r ? S_CLR : S_DONE;
            end else begin
              state_nxt = S_XA;
            end
            ptr_nxt = '0;
          end
          OP_READ_BIN: begin
            if (!built_r) begin
              status_nxt = ST_NOT_BUILT;
            end else begin
              state_nxt = S_RDW;
            end
          end
          OP_READ_SLT: begin
            if (!built_r) begin
              status_nxt = ST_NOT_BUILT;
            end else if (CNT_W'(idx_r) >= cells_r) begin
              status_nxt = ST_CELL_OVF;
            end else begin
              state_nxt = S_RDW;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // Cell bin along each axis; negative positions divide zero.
      S_XA: begin
        div_req.start    = 1'b1;
        div_req.dividend = px_r[POS_W-1] ? '0 : px_r[REG_W-1:0];
        state_nxt        = S_XW;
      end
      S_XW: begin
        if (div_rsp.done) begin
          bx_nxt    = clamp_b;
          state_nxt = S_YA;
        end
      end
      S_YA: begin
        div_req.start    = 1'b1;
        div_req.dividend = py_r[POS_W-1] ? '0 : py_r[REG_W-1:0];
        state_nxt        = S_YW;
      end
      S_YW: begin
        if (div_rsp.done) begin
          by_nxt    = clamp_b;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cb_we     = 1'b1;
        cells_nxt = cells_r + 1'b1;
        state_nxt = last_r ? S_CLR : S_DONE;
      end
      // Read data arrives from the memories addressed in the dispatch cycle.
      S_RDW: begin
        if (op_r == OP_READ_BIN) begin
          bstart_nxt = st_rdata;
          bcount_nxt = cn_rdata;
        end else begin
          scell_nxt = so_rdata;
        end
        state_nxt = S_DONE;
      end
      // Build: clear the counts.
      S_CLR: begin
        cn_we    = 1'b1;
        cn_wdata = '0;
        ptr_nxt  = ptr_r + 1'b1;
        if (ptr_r == CNT_W'(MAX_BINS - 1)) begin
          ptr_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = (cells_r == '0) ? S_PFX_A : S_CNT_A;
        end
      end
      // Count cells per bin, one read-modify-write per cell.
      S_CNT_A: state_nxt = S_CNT_B;
      S_CNT_B: begin
        cb_nxt    = cb_rdata;
        cn_raddr  = cb_rdata;
        state_nxt = S_CNT_C;
      end
      S_CNT_C: begin
        cn_we    = 1'b1;
        cn_waddr = cb_r;
        cn_wdata = cn_rdata + 1'b1;
        ptr_nxt  = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == cells_r) begin
          ptr_nxt   = '0;
          state_nxt = S_PFX_A;
        end else begin
          state_nxt = S_CNT_A;
        end
      end
      // Running sum of counts into start offsets and cursors.
      S_PFX_A: begin
        cn_raddr  = ptr_r[BIN_AW-1:0];
        state_nxt = S_PFX_B;
      end
      S_PFX_B: begin
        st_we   = 1'b1;
        cu_we   = 1'b1;
        acc_nxt = acc_r + cn_rdata;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CNT_W'(MAX_BINS - 1)) begin
          ptr_nxt = '0;
          if (cells_r == '0) begin
            built_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SC_A;
          end
        end else begin
          state_nxt = S_PFX_A;
        end
      end
      // Scatter cell indices into the sorted list in index order.
      S_SC_A: state_nxt = S_SC_B;
      S_SC_B: begin
        cb_nxt    = cb_rdata;
        cu_raddr  = cb_rdata;
        state_nxt = S_SC_C;
      end
      S_SC_C: begin
        so_we    = (cu_rdata < CNT_W'(MAX_CELLS));
        cu_we    = 1'b1;
        cu_waddr = cb_r;
        cu_wdata = cu_rdata + 1'b1;
        ptr_nxt  = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == cells_r) begin
          built_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SC_A;
        end
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.bin_base    = bstart_r;
          out_data_nxt.bin_size    = bcount_r;
          out_data_nxt.sorted_cell = scell_r;
          out_data_nxt.bins_across = (across_r > DIM_W'(SAT_BINS)) ? SAT_BINS
                                                                   : across_r[OUT_W-1:0];
          out_data_nxt.bins_down   = (down_r > DIM_W'(SAT_BINS)) ? SAT_BINS
                                                                 : down_r[OUT_W-1:0];
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cells_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cells_r     <= cells_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    side_r     <= side_nxt;
    across_r   <= across_nxt;
    down_r     <= down_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    acc_r      <= acc_nxt;
    cb_r       <= cb_nxt;
    status_r   <= status_nxt;
    bstart_r   <= bstart_nxt;
    bcount_r   <= bcount_nxt;
    scell_r    <= scell_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks.
  `SBCS_ASSERT(a_cells_bound, 1'b1, cells_r <= CNT_W'(MAX_CELLS), "cell count past capacity")
  `SBCS_ASSERT(a_store_in_grid, state_r == S_STORE,
    (DIM_W'(bx_r) < across_r) && (DIM_W'(by_r) < down_r), "stored bin outside grid")
  `SBCS_ASSERT_NXT(a_built_src, !built_r && state_r != S_SC_C && state_r != S_PFX_B,
    !built_r, "built flag set outside the build")
  `SBCS_ASSERT_NXT(a_out_src, !out_valid_r && state_r != S_DONE, !out_valid_r,
    "result shown without a finished item")

endmodule

/* design/sbcs_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module sbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sbcs_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on sbcs_pkg for the request and response types.
module sbcs_divider
  import sbcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [SIDE_W-1:0] rem_r, rem_nxt;
  logic [REG_W-1:0]  quo_r, quo_nxt;
  logic [SIDE_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SIDE_W:0]   shifted;
  logic [SIDE_W:0]   trial;

  // One shift and subtract step per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[REG_W-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = DIV_CW'(REG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[SIDE_W]) begin
        rem_nxt = trial[SIDE_W-1:0];
        quo_nxt = {quo_r[REG_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[SIDE_W-1:0];
        quo_nxt = {quo_r[REG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
